FILE: src/ptc_pkg.sv
package ptc_pkg;

    localparam int unsigned DivSteps = 32;

    localparam logic [1:0] REG_TEMP_COEFFS  = 2'd0;
    localparam logic [1:0] REG_PRESS_LOW    = 2'd1;
    localparam logic [1:0] REG_PRESS_HIGH   = 2'd2;
    localparam logic [1:0] REG_PRESS_NINE   = 2'd3;

    localparam logic signed [31:0] TempMin  = -32'sd4000;
    localparam logic signed [31:0] TempMax  = 32'sd8500;
    localparam logic [31:0]        PressMax = 32'd131071;
    localparam logic [31:0]        FineOfs  = 32'd64000;
    localparam logic [31:0]        P1Ofs    = 32'd32768;
    localparam logic [31:0]        PressFs  = 32'd1048576;
    localparam logic [31:0]        PressMul = 32'd3125;
    localparam logic [31:0]        RoundOfs = 32'd128;

    // sideband that rides along the divider
    typedef struct packed {
        logic signed [14:0] temp;
        logic               zero;
        logic               dbl;
    } div_side_t;

    function automatic logic [31:0] sar(input logic [31:0] v, input int unsigned n);
        return 32'($signed(v) >>> n);
    endfunction

    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] prod;
        prod = a * b;
        return prod[31:0];
    endfunction

    function automatic logic [31:0] sext16(input logic [15:0] f);
        return {{16{f[15]}}, f};
    endfunction

endpackage

FILE: src/pressure_temperature_compensation_core.sv
// channel  | handshake                   | payload
// input    | in_valid / in_stall         | raw_temperature, raw_pressure
// output   | out_valid / out_stall       | temperature_centi, pressure_pa
// config   | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// One word enters per cycle unless the output stalls; the pipe has 11 stages of
// multiply and shift, 32 stages of a one-bit-per-stage restoring divider, 3 closing stages.
// Reset clears valid bits and the coefficient registers; no clearing pass.
// A stalled output word freezes the whole pipeline and stalls the input.
// cfg_ready is always high; the user must write config only while the pipe is empty (not enforced).
module pressure_temperature_compensation_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [19:0]        raw_temperature,
    input  logic [19:0]        raw_pressure,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [14:0] temperature_centi,
    output logic [16:0]        pressure_pa,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data
);
    import ptc_pkg::*;

    logic [47:0] temp_coeffs_reg;
    logic [63:0] press_low_reg;
    logic [63:0] press_high_reg;
    logic [15:0] press_nine_reg;

    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic        adv;

    assign cfg_ready = 1'b1;
    assign adv       = !(out_valid && out_stall);
    assign in_stall  = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_coeffs_reg <= '0;
            press_low_reg   <= '0;
            press_high_reg  <= '0;
            press_nine_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_TEMP_COEFFS: temp_coeffs_reg <= cfg_data[47:0];
                REG_PRESS_LOW:   press_low_reg   <= cfg_data;
                REG_PRESS_HIGH:  press_high_reg  <= cfg_data;
                REG_PRESS_NINE:  press_nine_reg  <= cfg_data[15:0];
                default:         press_nine_reg  <= press_nine_reg;
            endcase
        end
    end

    always_comb
    begin
        t1 = {16'd0, temp_coeffs_reg[15:0]};
        t2 = sext16(temp_coeffs_reg[31:16]);
        t3 = sext16(temp_coeffs_reg[47:32]);
        p1 = {16'd0, press_low_reg[15:0]};
        p2 = sext16(press_low_reg[31:16]);
        p3 = sext16(press_low_reg[47:32]);
        p4 = sext16(press_low_reg[63:48]);
        p5 = sext16(press_high_reg[15:0]);
        p6 = sext16(press_high_reg[31:16]);
        p7 = sext16(press_high_reg[47:32]);
        p8 = sext16(press_high_reg[63:48]);
        p9 = sext16(press_nine_reg);
    end

    // valid bits of the front stages
    logic [11:1] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[10:1], in_valid};
        end
    end

    // stage payload
    logic [19:0] tadc1_reg;
    logic [19:0] padc_reg [1:9];
    logic [31:0] a2_reg, b2_reg;
    logic [31:0] m1_3_reg, bb3_reg;
    logic [31:0] v1t4_reg, m2_4_reg;
    logic [31:0] fine5_reg;
    logic signed [14:0] temp_reg [6:11];
    logic [31:0] pv1_6_reg, q6_reg;
    logic [31:0] qq7_reg, m5_7_reg, m2p7_reg;
    logic [31:0] m6_8_reg, m3_8_reg, m5_8_reg, m2p8_reg;
    logic [31:0] v2_9_reg, v1b9_reg;
    logic [31:0] den10_reg, pre10_reg;
    logic [31:0] den11_reg, pm11_reg;

    logic [31:0] fine_sc;
    logic [31:0] temp_word;
    logic signed [14:0] temp_next;
    logic [31:0] pv1_next;

    always_comb
    begin
        fine_sc   = fine5_reg;
        temp_word = sar(32'(fine_sc * 32'd5) + RoundOfs, 8);
        if ($signed(temp_word) < TempMin)
        begin
            temp_next = 15'(TempMin);
        end
        else if ($signed(temp_word) > TempMax)
        begin
            temp_next = 15'(TempMax);
        end
        else
        begin
            temp_next = temp_word[14:0];
        end
        pv1_next = sar(fine_sc, 1) - FineOfs;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tadc1_reg   <= raw_temperature;
            padc_reg[1] <= raw_pressure;
            for (int i = 2; i <= 9; i++)
            begin
                padc_reg[i] <= padc_reg[i-1];
            end
            a2_reg    <= ({12'd0, tadc1_reg} >> 3) - (t1 << 1);
            b2_reg    <= ({12'd0, tadc1_reg} >> 4) - t1;
            m1_3_reg  <= mul32(a2_reg, t2);
            bb3_reg   <= mul32(b2_reg, b2_reg);
            v1t4_reg  <= sar(m1_3_reg, 11);
            m2_4_reg  <= mul32(sar(bb3_reg, 12), t3);
            fine5_reg <= v1t4_reg + sar(m2_4_reg, 14);
            temp_reg[6] <= temp_next;
            for (int i = 7; i <= 11; i++)
            begin
                temp_reg[i] <= temp_reg[i-1];
            end
            pv1_6_reg <= pv1_next;
            q6_reg    <= sar(pv1_next, 2);
            qq7_reg   <= mul32(q6_reg, q6_reg);
            m5_7_reg  <= mul32(pv1_6_reg, p5);
            m2p7_reg  <= mul32(p2, pv1_6_reg);
            m6_8_reg  <= mul32(sar(qq7_reg, 11), p6);
            m3_8_reg  <= mul32(p3, sar(qq7_reg, 13));
            m5_8_reg  <= m5_7_reg;
            m2p8_reg  <= m2p7_reg;
            v2_9_reg  <= sar(m6_8_reg + (m5_8_reg << 1), 2) + (p4 << 16);
            v1b9_reg  <= sar(sar(m3_8_reg, 3) + sar(m2p8_reg, 1), 18);
            den10_reg <= sar(mul32(P1Ofs + v1b9_reg, p1), 15);
            pre10_reg <= (PressFs - {12'd0, padc_reg[9]}) - sar(v2_9_reg, 12);
            den11_reg <= den10_reg;
            pm11_reg  <= mul32(pre10_reg, PressMul);
        end
    end

    // divider
    div_side_t   side_in, side_out;
    logic [31:0] dvd_in, quo;
    logic        div_vld;

    always_comb
    begin
        side_in.temp = temp_reg[11];
        side_in.zero = den11_reg == '0;
        side_in.dbl  = pm11_reg[31];
        dvd_in       = pm11_reg[31] ? pm11_reg : {pm11_reg[30:0], 1'b0};
    end

    ptc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (vld_reg[11]),
        .dividend (dvd_in),
        .divisor  (den11_reg),
        .in_side  (side_in),
        .out_vld  (div_vld),
        .quotient (quo),
        .out_side (side_out)
    );

    // closing stages
    logic [2:1]  tail_vld_reg;
    logic        out_valid_reg;
    div_side_t   side_t1_reg, side_t2_reg;
    logic [31:0] p_t1_reg, aa_t1_reg, m8_t1_reg;
    logic [31:0] p_t2_reg, m9_t2_reg, m8_t2_reg;
    logic signed [14:0] temp_out_reg;
    logic [16:0] press_out_reg;
    logic [31:0] p_div, a_div, p_fin;
    logic [16:0] press_next;

    always_comb
    begin
        p_div = side_out.dbl ? {quo[30:0], 1'b0} : quo;
        a_div = p_div >> 3;
        p_fin = p_t2_reg + sar(sar(m9_t2_reg, 12) + sar(m8_t2_reg, 13) + p7, 4);
        if (side_t2_reg.zero || p_fin[31])
        begin
            press_next = '0;
        end
        else if (p_fin > PressMax)
        begin
            press_next = PressMax[16:0];
        end
        else
        begin
            press_next = p_fin[16:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_vld_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            tail_vld_reg  <= {tail_vld_reg[1], div_vld};
            out_valid_reg <= tail_vld_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_t1_reg   <= side_out;
            p_t1_reg      <= p_div;
            aa_t1_reg     <= mul32(a_div, a_div);
            m8_t1_reg     <= mul32(p_div >> 2, p8);
            side_t2_reg   <= side_t1_reg;
            p_t2_reg      <= p_t1_reg;
            m9_t2_reg     <= mul32(p9, aa_t1_reg >> 13);
            m8_t2_reg     <= m8_t1_reg;
            temp_out_reg  <= side_t2_reg.temp;
            press_out_reg <= press_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign temperature_centi = temp_out_reg;
    assign pressure_pa       = press_out_reg;

endmodule

FILE: src/ptc_div.sv
module ptc_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_vld,
    input  logic [31:0]           dividend,
    input  logic [31:0]           divisor,
    input  ptc_pkg::div_side_t    in_side,
    output logic                  out_vld,
    output logic [31:0]           quotient,
    output ptc_pkg::div_side_t    out_side
);
    import ptc_pkg::*;

    logic [DivSteps:0]  vld_reg;
    logic [31:0]        rem_reg  [0:DivSteps];
    logic [31:0]        dq_reg   [0:DivSteps];
    logic [31:0]        den_reg  [0:DivSteps];
    div_side_t          side_reg [0:DivSteps];

    always_comb
    begin
        vld_reg[0]  = in_vld;
        rem_reg[0]  = '0;
        dq_reg[0]   = dividend;
        den_reg[0]  = divisor;
        side_reg[0] = in_side;
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 1; k <= DivSteps; k++) begin : g_step
        logic [32:0] trial;
        logic        ge;
        logic [31:0] rem_next;
        logic [31:0] dq_next;

        always_comb
        begin
            trial    = {rem_reg[k-1], dq_reg[k-1][31]};
            ge       = trial >= {1'b0, den_reg[k-1]};
            rem_next = ge ? 32'(trial - {1'b0, den_reg[k-1]}) : trial[31:0];
            dq_next  = {dq_reg[k-1][30:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k]  <= rem_next;
                dq_reg[k]   <= dq_next;
                den_reg[k]  <= den_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_vld  = vld_reg[DivSteps];
    assign quotient = dq_reg[DivSteps];
    assign out_side = side_reg[DivSteps];

endmodule

FILE: src/ptc_checker.sv
module ptc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic [19:0]        raw_temperature,
    input logic [19:0]        raw_pressure,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [14:0] temperature_centi,
    input logic [16:0]        pressure_pa,
    input logic               cfg_valid,
    input logic               cfg_ready
);

    // hold a stalled output word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(temperature_centi)
            && $stable(pressure_pa))
        else $error("stalled output word changed");

    // hold a stalled input word
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(raw_temperature)
            && $stable(raw_pressure))
        else $error("stalled input word changed");

    // temperature stays in its clamp range
    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> temperature_centi >= -15'sd4000 && temperature_centi <= 15'sd8500)
        else $error("temperature out of range");

    // input stalls only under output backpressure
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // config port always takes a word
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config word refused");

endmodule

bind pressure_temperature_compensation_core ptc_checker u_ptc_checker (.*);

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import ptc_pkg::*;

    typedef struct packed {
        logic [19:0] raw_t;
        logic [19:0] raw_p;
    } sample_t;

    typedef struct packed {
        logic signed [14:0] temp;
        logic [16:0]        press;
    } reading_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [19:0]        raw_temperature;
    logic [19:0]        raw_pressure;
    logic               out_valid;
    logic               out_stall;
    logic signed [14:0] temperature_centi;
    logic [16:0]        pressure_pa;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [63:0]        cfg_data;

    pressure_temperature_compensation_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .raw_temperature(raw_temperature), .raw_pressure(raw_pressure),
        .out_valid(out_valid), .out_stall(out_stall),
        .temperature_centi(temperature_centi), .pressure_pa(pressure_pa),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // coefficient shadow
    logic [47:0] temp_coeff_reg;
    logic [63:0] press_low_reg;
    logic [63:0] press_high_reg;
    logic [15:0] press_nine_reg;

    sample_t  pending_samples[$];
    reading_t expected_readings[$];
    int       errors;
    int       idle_cycles;
    int       gap_left;
    int       stall_left;
    bit       hold_input;
    bit       feeding;

    localparam int WatchdogLimit = 20000;
    localparam int PipeLatency   = 46;

    function automatic logic [31:0] ashr(input logic [31:0] v, input int n);
        return 32'($signed(v) >>> n);
    endfunction

    function automatic logic [31:0] mlo(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] full;
        full = a * b;
        return full[31:0];
    endfunction

    function automatic logic [31:0] sx(input logic [15:0] f);
        return {{16{f[15]}}, f};
    endfunction

    function automatic reading_t compensate(input sample_t s);
        logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] a, b, fine, t, v1, v2, q, p;
        logic signed [31:0] ts, ps;
        reading_t r;
        t1 = {16'd0, temp_coeff_reg[15:0]};
        t2 = sx(temp_coeff_reg[31:16]);
        t3 = sx(temp_coeff_reg[47:32]);
        p1 = {16'd0, press_low_reg[15:0]};
        p2 = sx(press_low_reg[31:16]);
        p3 = sx(press_low_reg[47:32]);
        p4 = sx(press_low_reg[63:48]);
        p5 = sx(press_high_reg[15:0]);
        p6 = sx(press_high_reg[31:16]);
        p7 = sx(press_high_reg[47:32]);
        p8 = sx(press_high_reg[63:48]);
        p9 = sx(press_nine_reg);

        a = ({12'd0, s.raw_t} >> 3) - (t1 << 1);
        v1 = ashr(mlo(a, t2), 11);
        b = ({12'd0, s.raw_t} >> 4) - t1;
        v2 = ashr(mlo(ashr(mlo(b, b), 12), t3), 14);
        fine = v1 + v2;
        t = ashr(mlo(fine, 32'd5) + 32'd128, 8);
        ts = $signed(t);
        if (ts < -4000) ts = -4000;
        if (ts > 8500) ts = 8500;
        r.temp = ts[14:0];

        v1 = ashr(fine, 1) - 32'd64000;
        q = ashr(v1, 2);
        v2 = mlo(ashr(mlo(q, q), 11), p6);
        v2 = v2 + (mlo(v1, p5) << 1);
        v2 = ashr(v2, 2) + (p4 << 16);
        v1 = ashr(ashr(mlo(p3, ashr(mlo(q, q), 13)), 3) + ashr(mlo(p2, v1), 1), 18);
        v1 = ashr(mlo(32'd32768 + v1, p1), 15);
        if (v1 == 0)
        begin
            r.press = '0;
            return r;
        end
        p = mlo((32'd1048576 - {12'd0, s.raw_p}) - ashr(v2, 12), 32'd3125);
        if (p < 32'h8000_0000)
            p = (p << 1) / v1;
        else
            p = (p / v1) * 32'd2;
        a = p >> 3;
        v1 = ashr(mlo(p9, mlo(a, a) >> 13), 12);
        v2 = ashr(mlo(p >> 2, p8), 13);
        p = p + ashr(v1 + v2 + p7, 4);
        ps = $signed(p);
        if (ps < 0) ps = 0;
        if (ps > 131071) ps = 131071;
        r.press = ps[16:0];
        return r;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 3) == 0)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid        <= 1'b0;
            raw_temperature <= '0;
            raw_pressure    <= '0;
            gap_left        <= 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
                expected_readings.push_back(compensate({raw_temperature, raw_pressure}));
            if (gap_left > 0 || hold_input || !feeding || pending_samples.size() == 0)
            begin
                in_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                sample_t s;
                s = pending_samples.pop_front();
                in_valid        <= 1'b1;
                raw_temperature <= s.raw_t;
                raw_pressure    <= s.raw_p;
                gap_left        <= pick_gap();
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            stall_left  <= 0;
            idle_cycles <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                reading_t want;
                if (expected_readings.size() == 0)
                begin
                    $display("%0t: unexpected word temp=%0d press=%0d", $time,
                             temperature_centi, pressure_pa);
                    errors++;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (temperature_centi !== want.temp)
                    begin
                        $display("%0t: temperature_centi expected %0d actual %0d",
                                 $time, want.temp, temperature_centi);
                        errors++;
                    end
                    if (pressure_pa !== want.press)
                    begin
                        $display("%0t: pressure_pa expected %0d actual %0d",
                                 $time, want.press, pressure_pa);
                        errors++;
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (stall_left > 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else
            begin
                out_stall  <= 1'b0;
                stall_left <= ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("pressure_temperature_compensation_core test failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_samples.size() != 0 || in_valid || expected_readings.size() != 0)
            @(posedge clk);
        repeat (PipeLatency + 4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_TEMP_COEFFS: temp_coeff_reg = val[47:0];
            REG_PRESS_LOW:   press_low_reg  = val;
            REG_PRESS_HIGH:  press_high_reg = val;
            REG_PRESS_NINE:  press_nine_reg = val[15:0];
            default: ;
        endcase
    endtask

    task automatic add_sample(input logic [19:0] rt, input logic [19:0] rp);
        sample_t s;
        s.raw_t = rt;
        s.raw_p = rp;
        pending_samples.push_back(s);
    endtask

    // typical part calibration
    task automatic load_typical();
        write_reg(REG_TEMP_COEFFS, 64'({16'hFC18, 16'd26435, 16'd27504}));
        write_reg(REG_PRESS_LOW, {16'd2855, 16'd8204, 16'hD0F5, 16'd36477});
        write_reg(REG_PRESS_HIGH, {16'hF17E, 16'd15500, 16'hFF8C, 16'd140});
        write_reg(REG_PRESS_NINE, 64'd6000);
    endtask

    task automatic random_phase(input int count, input bit near_typical);
        repeat (count)
        begin
            if (near_typical && $urandom_range(0, 4) != 0)
                add_sample(20'(($urandom_range(380000, 620000))),
                           20'(($urandom_range(250000, 500000))));
            else
                add_sample(20'($urandom), 20'($urandom));
        end
    endtask

    initial
    begin
        errors          = 0;
        hold_input      = 1'b0;
        feeding         = 1'b0;
        temp_coeff_reg  = '0;
        press_low_reg   = '0;
        press_high_reg  = '0;
        press_nine_reg  = '0;
        cfg_valid       = 1'b0;
        cfg_index       = REG_TEMP_COEFFS;
        cfg_data        = '0;
        rst_n           = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all-zero coefficients: divisor zero path
        add_sample(20'd0, 20'd0);
        add_sample(20'hFFFFF, 20'hFFFFF);
        feeding = 1'b1;
        wait_drained();

        load_typical();
        add_sample(20'd519888, 20'd415148);
        add_sample(20'd0, 20'd0);
        add_sample(20'hFFFFF, 20'hFFFFF);
        add_sample(20'hFFFFF, 20'd0);
        add_sample(20'd0, 20'hFFFFF);
        add_sample(20'd300000, 20'd100000);
        add_sample(20'd700000, 20'd600000);
        add_sample(20'h55555, 20'hAAAAA);
        add_sample(20'hAAAAA, 20'h55555);
        random_phase(190, 1'b1);
        // hold the sender until the pipe is empty
        while (pending_samples.size() != 0)
            @(posedge clk);
        hold_input = 1'b1;
        wait_drained();
        hold_input = 1'b0;

        // extreme coefficients
        write_reg(REG_TEMP_COEFFS, 64'hFFFF_FFFF_FFFF);
        write_reg(REG_PRESS_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_PRESS_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_PRESS_NINE, 64'hFFFF);
        add_sample(20'd0, 20'd0);
        add_sample(20'hFFFFF, 20'hFFFFF);
        random_phase(100, 1'b0);
        wait_drained();

        write_reg(REG_TEMP_COEFFS, 64'({16'h8000, 16'h8000, 16'h0000}));
        write_reg(REG_PRESS_LOW, {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF});
        write_reg(REG_PRESS_HIGH, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
        write_reg(REG_PRESS_NINE, 64'h8000);
        add_sample(20'd0, 20'hFFFFF);
        random_phase(100, 1'b0);
        wait_drained();

        // random coefficients, biased toward sane ranges
        repeat (4)
        begin
            if ($urandom_range(0, 1))
                load_typical();
            write_reg(REG_TEMP_COEFFS, {$urandom, $urandom});
            write_reg(REG_PRESS_LOW, {$urandom, $urandom});
            if ($urandom_range(0, 1))
                write_reg(REG_PRESS_HIGH, {$urandom, $urandom});
            write_reg(REG_PRESS_NINE, {$urandom, $urandom});
            random_phase(100, 1'b1);
            wait_drained();
        end

        load_typical();
        random_phase(50, 1'b1);
        wait_drained();

        if (errors == 0)
            $display("pressure_temperature_compensation_core test passed");
        else
            $display("pressure_temperature_compensation_core test failed");
        $finish;
    end
endmodule

FILE: filelist.f
src/ptc_pkg.sv
src/ptc_div.sv
src/pressure_temperature_compensation_core.sv
src/ptc_checker.sv
tb/testbench.sv
